// File: hdl/ufe_pkg.sv
package ufe_pkg;

  localparam int unsigned NODES_DEF = 1024;
  localparam int unsigned NODE_W    = 10;

  // upc values, one per microprogram step
  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_CCHK,
    S_CWR,
    S_FDONE,
    S_PHS,
    S_JOIN,
    S_OUT,
    S_LDB,
    S_CLR
  } step_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_CLR,
    DP_ACCEPT,
    DP_WALK,
    DP_CCHK,
    DP_CWR,
    DP_LDB,
    DP_JOIN
  } dp_op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_ROOT,
    C_CUR_ROOT,
    C_IS_FIND,
    C_PHASE_B,
    C_OUT_FREE,
    C_CLR_DONE
  } cond_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_ld;
    cond_t  cond;
    step_t  jt;
    step_t  jf;
  } ctl_word_t;

  // condition flags from the datapath
  typedef struct packed {
    logic accept;
    logic root_hit;
    logic cur_root;
    logic is_find;
    logic phase_b;
    logic out_free;
    logic clr_done;
  } flags_t;

  // what the sequencer tells the datapath this cycle
  typedef struct packed {
    dp_op_t op;
    logic   out_ld;
    logic   taken;
  } seq_ctl_t;

endpackage

// File: hdl/union_find_engine_core.sv
// Disjoint-set engine with full path compression.
// Input channel (in_valid/in_stall): one beat per operation. in_opcode 0 finds
// the root of in_node_a; 1 joins the sets of in_node_a and in_node_b, the root
// of in_node_b becoming the root of the merged set. Node indices at or above
// NODES are clamped to NODES-1.
// Result channel (out_valid/out_stall): exactly one beat per operation with
// out_root and out_already_joined (always 0 for a find).
// One operation at a time, run by a microprogram over a parent table with one
// read and one write port and a registered read. A find walks the links to the
// root and then points each node on the path at it; a union does two such
// walks, the second from in_node_b, and then links the first root to the second.
// The result register is separate from the engine: the next operation is
// taken while a result is still held by out_stall; an operation stalls only
// in its final step if the previous result has not yet left.
// Reset (rst_n low, synchronous) starts a clearing pass that sets every table
// entry to its own index, one entry a cycle, with in_stall high throughout.
module union_find_engine_core
  import ufe_pkg::*;
#(
  parameter int unsigned NODES = NODES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] out_root,
  output logic              out_already_joined
);

  localparam int unsigned IDX_W = $clog2(NODES);
  localparam int unsigned CW    = (IDX_W > NODE_W) ? IDX_W : NODE_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NODES - 1);

  flags_t   flags;
  seq_ctl_t ctl;

  logic [IDX_W-1:0] parent_mem [NODES];

  logic             op_r, op_nxt;
  logic [IDX_W-1:0] b_r, b_nxt;
  logic [IDX_W-1:0] node_r, node_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] root_r, root_nxt;
  logic [IDX_W-1:0] ra_r, ra_nxt;
  logic             phase_r, phase_nxt;
  logic             joined_r, joined_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [IDX_W-1:0] rdata_r;
  logic              out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0] out_root_r, out_root_nxt;
  logic              out_joined_r, out_joined_nxt;

  logic [IDX_W-1:0] rd_addr, wr_addr, wr_data;
  logic             wr_en;
  logic [CW-1:0]    a_ext, b_ext, root_ext;
  logic [IDX_W-1:0] a_clamp, b_clamp;

  ufe_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  assign a_ext    = CW'(in_node_a);
  assign b_ext    = CW'(in_node_b);
  assign a_clamp  = (a_ext >= CW'(NODES - 1)) ? LAST : a_ext[IDX_W-1:0];
  assign b_clamp  = (b_ext >= CW'(NODES - 1)) ? LAST : b_ext[IDX_W-1:0];
  assign root_ext = CW'(root_r);

  assign in_stall = (ctl.op != DP_ACCEPT);

  assign flags.accept   = in_valid;
  assign flags.root_hit = (rdata_r == node_r);
  assign flags.cur_root = (cur_r == root_r);
  assign flags.is_find  = !op_r;
  assign flags.phase_b  = phase_r;
  assign flags.out_free = !out_valid_r || !out_stall;
  assign flags.clr_done = (clr_r == LAST);

  always_comb begin
    op_nxt         = op_r;
    b_nxt          = b_r;
    node_nxt       = node_r;
    start_nxt      = start_r;
    cur_nxt        = cur_r;
    root_nxt       = root_r;
    ra_nxt         = ra_r;
    phase_nxt      = phase_r;
    joined_nxt     = joined_r;
    clr_nxt        = clr_r;
    out_root_nxt   = out_root_r;
    out_joined_nxt = out_joined_r;
    out_valid_nxt  = out_valid_r && out_stall;
    rd_addr        = cur_r;
    wr_en          = 1'b0;
    wr_addr        = cur_r;
    wr_data        = root_r;
    case (ctl.op)
      DP_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      DP_ACCEPT: begin
        rd_addr = a_clamp;
        if (ctl.taken) begin
          op_nxt     = in_opcode;
          b_nxt      = b_clamp;
          node_nxt   = a_clamp;
          start_nxt  = a_clamp;
          phase_nxt  = 1'b0;
          joined_nxt = 1'b0;
        end
      end
      DP_WALK: begin
        // follow one link a cycle; read address comes straight off the last read
        if (ctl.taken) begin
          root_nxt = node_r;
          cur_nxt  = start_r;
        end else begin
          node_nxt = rdata_r;
          rd_addr  = rdata_r;
        end
      end
      DP_CCHK: begin
        rd_addr = cur_r;
      end
      DP_CWR: begin
        wr_en   = 1'b1;
        wr_addr = cur_r;
        wr_data = root_r;
        cur_nxt = rdata_r;
      end
      DP_LDB: begin
        ra_nxt    = root_r;
        phase_nxt = 1'b1;
        node_nxt  = b_r;
        start_nxt = b_r;
        rd_addr   = b_r;
      end
      DP_JOIN: begin
        joined_nxt = (ra_r == root_r);
        wr_en      = (ra_r != root_r);
        wr_addr    = ra_r;
        wr_data    = root_r;
      end
      default: begin
      end
    endcase
    if (ctl.out_ld && ctl.taken) begin
      out_valid_nxt  = 1'b1;
      out_root_nxt   = root_ext[NODE_W-1:0];
      out_joined_nxt = op_r & joined_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      parent_mem[wr_addr] <= wr_data;
    end
    rdata_r <= parent_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    b_r          <= b_nxt;
    node_r       <= node_nxt;
    start_r      <= start_nxt;
    cur_r        <= cur_nxt;
    root_r       <= root_nxt;
    ra_r         <= ra_nxt;
    phase_r      <= phase_nxt;
    joined_r     <= joined_nxt;
    out_root_r   <= out_root_nxt;
    out_joined_r <= out_joined_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_root           = out_root_r;
  assign out_already_joined = out_joined_r;

endmodule

// File: hdl/ufe_seq.sv
module ufe_seq
  import ufe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  flags_t   flags,
  output seq_ctl_t ctl
);

  step_t     upc_r, upc_nxt;
  ctl_word_t word;
  logic      taken;

  // microprogram ROM
  always_comb begin
    case (upc_r)
      S_IDLE:  word = '{op: DP_ACCEPT, out_ld: 1'b0, cond: C_ACCEPT,   jt: S_WALK,  jf: S_IDLE};
      S_WALK:  word = '{op: DP_WALK,   out_ld: 1'b0, cond: C_ROOT,     jt: S_CCHK,  jf: S_WALK};
      S_CCHK:  word = '{op: DP_CCHK,   out_ld: 1'b0, cond: C_CUR_ROOT, jt: S_FDONE, jf: S_CWR};
      S_CWR:   word = '{op: DP_CWR,    out_ld: 1'b0, cond: C_ALWAYS,   jt: S_CCHK,  jf: S_CCHK};
      S_FDONE: word = '{op: DP_NOP,    out_ld: 1'b0, cond: C_IS_FIND,  jt: S_OUT,   jf: S_PHS};
      S_PHS:   word = '{op: DP_NOP,    out_ld: 1'b0, cond: C_PHASE_B,  jt: S_JOIN,  jf: S_LDB};
      S_JOIN:  word = '{op: DP_JOIN,   out_ld: 1'b0, cond: C_ALWAYS,   jt: S_OUT,   jf: S_OUT};
      S_OUT:   word = '{op: DP_NOP,    out_ld: 1'b1, cond: C_OUT_FREE, jt: S_IDLE,  jf: S_OUT};
      S_LDB:   word = '{op: DP_LDB,    out_ld: 1'b0, cond: C_ALWAYS,   jt: S_WALK,  jf: S_WALK};
      S_CLR:   word = '{op: DP_CLR,    out_ld: 1'b0, cond: C_CLR_DONE, jt: S_IDLE,  jf: S_CLR};
      default: word = '{op: DP_NOP,    out_ld: 1'b0, cond: C_ALWAYS,   jt: S_IDLE,  jf: S_IDLE};
    endcase
  end

  always_comb begin
    case (word.cond)
      C_ALWAYS:   taken = 1'b1;
      C_ACCEPT:   taken = flags.accept;
      C_ROOT:     taken = flags.root_hit;
      C_CUR_ROOT: taken = flags.cur_root;
      C_IS_FIND:  taken = flags.is_find;
      C_PHASE_B:  taken = flags.phase_b;
      C_OUT_FREE: taken = flags.out_free;
      C_CLR_DONE: taken = flags.clr_done;
      default:    taken = 1'b0;
    endcase
    upc_nxt    = taken ? word.jt : word.jf;
    ctl.op     = word.op;
    ctl.out_ld = word.out_ld;
    ctl.taken  = taken;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_CLR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// File: hdl/ufe_chk.sv
module ufe_chk
  import ufe_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [NODE_W-1:0] out_root,
  input logic              out_already_joined
);

  // held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_root) && $stable(out_already_joined))
    else $error("result beat changed while stalled");

  // reset starts the clearing pass, so the input is closed next cycle
  a_rst_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open straight after reset");

  // one operation in flight: an accepted beat closes the input
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat accepted while busy");

  // a new result only appears from a busy engine
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without an operation in progress");

endmodule

bind union_find_engine_core ufe_chk u_ufe_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_root           (out_root),
  .out_already_joined (out_already_joined)
);

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ufe_pkg::*;

  localparam int unsigned NODE_COUNT  = NODES_DEF;
  localparam int unsigned STALL_LIMIT = 30000;  // covers the worst walk plus the clearing pass
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned REPORT_MAX  = 10;

  typedef enum logic {
    OP_FIND  = 1'b0,
    OP_UNION = 1'b1
  } uf_op_e;

  typedef enum logic [1:0] {
    MODE_SLOW_SINK,
    MODE_SLOW_SOURCE,
    MODE_FULL_RATE
  } traffic_e;

  typedef struct {
    uf_op_e            op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              drain_first;
    traffic_e          mode;
  } set_cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] root;
    logic              joined;
  } set_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_opcode = 1'b0;
  logic [NODE_W-1:0] in_node_a = '0;
  logic [NODE_W-1:0] in_node_b = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [NODE_W-1:0] out_root;
  logic              out_already_joined;

  set_cmd_t          cmd_q[$];
  set_result_t       root_expect_q[$];
  logic [NODE_W-1:0] parent_model [NODE_COUNT];
  traffic_e          traffic_mode = MODE_SLOW_SINK;
  int unsigned       issued_cnt = 0;
  int unsigned       retired_cnt = 0;
  int unsigned       fail_cnt = 0;
  int unsigned       quiet_cycles = 0;

  union_find_engine_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_node_a          (in_node_a),
    .in_node_b          (in_node_b),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_root           (out_root),
    .out_already_joined (out_already_joined)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [NODE_W-1:0] clamp_node(input logic [NODE_W-1:0] n);
    if (int'(n) >= NODE_COUNT) return NODE_W'(NODE_COUNT - 1);
    return n;
  endfunction

  // walk to the root, then point every node on the path straight at it
  function automatic logic [NODE_W-1:0] find_and_compress(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] r;
    logic [NODE_W-1:0] cur;
    logic [NODE_W-1:0] nxt;
    int unsigned hops;
    r = node;
    hops = 0;
    while (parent_model[r] != r && hops < NODE_COUNT) begin
      r = parent_model[r];
      hops++;
    end
    cur = node;
    hops = 0;
    while (cur != r && hops < NODE_COUNT) begin
      nxt = parent_model[cur];
      parent_model[cur] = r;
      cur = nxt;
      hops++;
    end
    return r;
  endfunction

  function automatic void apply_set_op(input logic opc, input logic [NODE_W-1:0] na,
                                       input logic [NODE_W-1:0] nb);
    logic [NODE_W-1:0] ra;
    logic [NODE_W-1:0] rb;
    set_result_t res;
    ra = find_and_compress(clamp_node(na));
    if (uf_op_e'(opc) == OP_FIND) begin
      res.root = ra;
      res.joined = 1'b0;
    end else begin
      rb = find_and_compress(clamp_node(nb));
      res.joined = (ra == rb);
      if (ra != rb) parent_model[ra] = rb;
      res.root = rb;
    end
    root_expect_q.push_back(res);
  endfunction

  task automatic add_cmd(input uf_op_e op, input int unsigned a, input int unsigned b);
    set_cmd_t c;
    c.op = op;
    c.node_a = NODE_W'(a);
    c.node_b = NODE_W'(b);
    c.drain_first = 1'b0;
    c.mode = MODE_SLOW_SINK;
    cmd_q.push_back(c);
  endtask

  // driver: a beat held under stall keeps its payload; prediction on acceptance
  always @(posedge clk) begin
    set_cmd_t    nxt;
    int unsigned idle_pct;
    logic        launch;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        apply_set_op(in_opcode, in_node_a, in_node_b);
        issued_cnt <= issued_cnt + 1;
      end
      launch = 1'b0;
      if (cmd_q.size() != 0) begin
        nxt = cmd_q[0];
        case (nxt.mode)
          MODE_SLOW_SINK:   idle_pct = 7;
          MODE_SLOW_SOURCE: idle_pct = 64;
          default:          idle_pct = 0;
        endcase
        if (nxt.drain_first && (issued_cnt + in_valid != retired_cnt)) launch = 1'b0;
        else launch = ($urandom_range(99) >= idle_pct);
      end
      if (launch) begin
        void'(cmd_q.pop_front());
        in_valid     <= 1'b1;
        in_opcode    <= nxt.op;
        in_node_a    <= nxt.node_a;
        in_node_b    <= nxt.node_b;
        traffic_mode <= nxt.mode;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: result beats against the oldest prediction
  always @(posedge clk) begin
    set_result_t want;
    int unsigned stall_pct;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (retired_cnt == issued_cnt) begin
          if (fail_cnt < REPORT_MAX)
            $display("unexpected result beat: root=%0d joined=%0b",
                     out_root, out_already_joined);
          fail_cnt++;
        end else begin
          want = root_expect_q.pop_front();
          retired_cnt <= retired_cnt + 1;
          if (out_root !== want.root || out_already_joined !== want.joined) begin
            if (fail_cnt < REPORT_MAX)
              $display("result %0d mismatch: root exp %0d got %0d, joined exp %0b got %0b",
                       retired_cnt, want.root, out_root, want.joined, out_already_joined);
            fail_cnt++;
          end
        end
      end
      case (traffic_mode)
        MODE_SLOW_SINK:   stall_pct = 64;
        MODE_SLOW_SOURCE: stall_pct = 7;
        default:          stall_pct = 0;
      endcase
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("union_find_engine_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned base;
    int unsigned span;
    int unsigned len;
    int unsigned kind;
    int unsigned total;
    traffic_e    m;
    for (int i = 0; i < NODE_COUNT; i++) parent_model[i] = NODE_W'(i);

    // directed: field extremes, self-union, repeat union, deep chain then compression
    add_cmd(OP_FIND, 0, 1023);
    add_cmd(OP_FIND, 1023, 0);
    add_cmd(OP_FIND, 10'h2AA, 10'h155);
    add_cmd(OP_FIND, 10'h155, 10'h2AA);
    add_cmd(OP_UNION, 0, 1023);
    add_cmd(OP_UNION, 1023, 0);
    add_cmd(OP_UNION, 5, 5);
    add_cmd(OP_FIND, 0, 0);
    add_cmd(OP_UNION, 1, 2);
    add_cmd(OP_UNION, 2, 3);
    add_cmd(OP_UNION, 3, 4);
    add_cmd(OP_UNION, 4, 6);
    add_cmd(OP_FIND, 1, 0);
    add_cmd(OP_FIND, 2, 0);
    add_cmd(OP_UNION, 6, 10'h155);
    add_cmd(OP_UNION, 1, 1023);
    add_cmd(OP_UNION, 10'h3FF, 10'h000);
    add_cmd(OP_UNION, 10'h2AA, 10'h155);
    add_cmd(OP_FIND, 3, 1023);
    add_cmd(OP_UNION, 10'h155, 1);
    add_cmd(OP_FIND, 10'h2AA, 0);

    while (cmd_q.size() < 1820) begin
      kind = $urandom_range(9);
      base = $urandom_range(1023);
      if (kind <= 5) begin
        // tight pool of nodes so sets merge and paths get compressed
        span = $urandom_range(48, 4);
        len = $urandom_range(30, 5);
        for (int i = 0; i < len; i++)
          add_cmd(uf_op_e'($urandom_range(1)), (base + $urandom_range(span - 1)) & 10'h3FF,
                  (base + $urandom_range(span - 1)) & 10'h3FF);
      end else if (kind <= 7) begin
        // linked chain, then a find from the far end and finds at random points along it
        len = $urandom_range(40, 3);
        for (int i = 0; i < len; i++)
          add_cmd(OP_UNION, (base + i) & 10'h3FF, (base + i + 1) & 10'h3FF);
        add_cmd(OP_FIND, base, $urandom_range(1023));
        for (int i = 0; i < 3; i++)
          add_cmd(OP_FIND, (base + $urandom_range(len)) & 10'h3FF, $urandom_range(1023));
      end else begin
        len = $urandom_range(10, 1);
        for (int i = 0; i < len; i++)
          add_cmd(uf_op_e'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023));
      end
    end

    total = cmd_q.size();
    for (int i = 0; i < total; i++) begin
      m = traffic_e'((i * 3) / total);
      cmd_q[i].mode = m;
      if ((i > 0 && m != cmd_q[i-1].mode) || i == 20 || $urandom_range(99) == 0)
        cmd_q[i].drain_first = 1'b1;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (cmd_q.size() != 0 || in_valid || issued_cnt != retired_cnt) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (root_expect_q.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("union_find_engine_core verification clean");
    end else begin
      $display("union_find_engine_core verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/ufe_pkg.sv
hdl/ufe_seq.sv
hdl/union_find_engine_core.sv
hdl/ufe_chk.sv
verif/tb_top.sv
